### hw/rtl/nearest_point_search_3d_macros.svh
// Assertion macros for the nearest point search block
`ifndef NEAREST_POINT_SEARCH_3D_MACROS_SVH
`define NEAREST_POINT_SEARCH_3D_MACROS_SVH

// clocked property, disabled while reset is held
`define NPSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define NPSD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/npsd_pkg.sv
// Types and constants shared by the nearest point search block
`timescale 1ns / 1ps
`default_nettype none

package npsd_pkg;

	localparam int COORD_W   = 16;
	localparam int IDX_OUT_W = 6;
	localparam int SQ_W      = 2 * COORD_W;
	localparam int DIST_W    = 2 * COORD_W + 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [1:0] STAT_INSERTED = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_FOUND    = 2'd2;
	localparam logic [1:0] STAT_EMPTY    = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		logic   operation;
		coord_t coord_x;
		coord_t coord_y;
		coord_t coord_z;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [IDX_OUT_W-1:0] match_index;
		coord_t               near_x;
		coord_t               near_y;
		coord_t               near_z;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_tag_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WAIT
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/nearest_point_search_3d.sv
// Top level of the 3D nearest point search: ring of point cells plus control
// Insert, or query on an empty table: result in the cycle after the transaction, busy stays low.
// Query: busy until the ring of cells has rotated once past the single distance pipeline
// at its head, one point per cycle, and the result of the last stored point has come
// out of that pipeline.
// Reset clears the point count and control; stored points are undefined until inserted.
// Results are one-cycle strobes on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_point_search_3d_macros.svh"

module nearest_point_search_3d import npsd_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t item,
	output logic          done,
	output out_item_t     result
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] step_q;
	point_t           qry_q;
	logic             seen_q;
	logic             res_vld_q;
	out_item_t        res_q;

	logic             accept;
	logic             full;
	logic             load_en;
	logic             shift;
	logic             scan_go;
	point_t           new_pt;
	scan_tag_t        tag;
	logic             dist_done;
	out_item_t        dist_res;
	point_t           cell_pt [MAX_POINTS];

	assign accept  = start && !busy;
	assign full    = (count_q == CNT_W'(MAX_POINTS));
	assign load_en = accept && (item.operation == OP_INSERT) && !full;
	assign scan_go = accept && (item.operation == OP_QUERY) && (count_q != '0);
	assign shift   = (state_q == S_SCAN);
	assign new_pt  = '{x: item.coord_x, y: item.coord_y, z: item.coord_z};

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		npsd_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.load     (load_en && (count_q == CNT_W'(i))),
			.shift_in (cell_pt[(i + 1) % MAX_POINTS]),
			.load_pt  (new_pt),
			.pt       (cell_pt[i])
		);
	end

	always_comb begin
		tag.valid = shift && (CNT_W'(step_q) < count_q);
		tag.first = (step_q == '0);
		tag.last  = ((CNT_W'(step_q) + CNT_W'(1)) == count_q);
	end

	npsd_dist #(
		.IDX_W (IDX_W)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag),
		.idx    (step_q),
		.pt     (cell_pt[0]),
		.qry    (qry_q),
		.done   (dist_done),
		.result (dist_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (scan_go) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (step_q == IDX_W'(MAX_POINTS - 1)) state_d = S_WAIT;
			end
			S_WAIT: begin
				if (seen_q || dist_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = res_vld_q || dist_done;
		result = dist_done ? dist_res : res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			step_q    <= '0;
			seen_q    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= accept && !scan_go;
			if (load_en) count_q <= count_q + CNT_W'(1);
			if (scan_go) begin
				step_q <= '0;
			end else if (shift) begin
				step_q <= step_q + IDX_W'(1);
			end
			if (scan_go) begin
				seen_q <= 1'b0;
			end else if (dist_done) begin
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q             <= new_pt;
			res_q.match_index <= '0;
			res_q.near_x      <= '0;
			res_q.near_y      <= '0;
			res_q.near_z      <= '0;
			if (item.operation == OP_INSERT) begin
				res_q.status <= full ? STAT_FULL : STAT_INSERTED;
			end else begin
				res_q.status <= STAT_EMPTY;
			end
		end
	end

	`NPSD_ASSERT_NEVER(a_dist_idle, dist_done && (state_q == S_IDLE), "search result while idle")
	`NPSD_ASSERT_NEVER(a_count_max, count_q > CNT_W'(MAX_POINTS), "point count above capacity")
	`NPSD_ASSERT(a_insert_cnt, load_en |=> (count_q == $past(count_q) + CNT_W'(1)), "insert lost")
	`NPSD_ASSERT_NEVER(a_strobe_clash, res_vld_q && dist_done, "two results in one cycle")

endmodule

`default_nettype wire

### hw/rtl/npsd_cell.sv
// One storage cell of the point ring: loads a new point or takes its neighbor's
`timescale 1ns / 1ps
`default_nettype none

module npsd_cell import npsd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   shift,
	input  wire logic   load,
	input  wire point_t shift_in,
	input  wire point_t load_pt,
	output point_t      pt
);

	point_t pt_q;

	always_ff @(posedge clk) begin
		if (load) begin
			pt_q <= load_pt;
		end else if (shift) begin
			pt_q <= shift_in;
		end
	end

	assign pt = pt_q;

endmodule

`default_nettype wire

### hw/rtl/npsd_dist.sv
// Squared distance pipeline and running minimum at the head of the point ring
`timescale 1ns / 1ps
`default_nettype none

module npsd_dist import npsd_pkg::*; #(
	parameter int IDX_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scan_tag_t        tag,
	input  wire logic [IDX_W-1:0] idx,
	input  wire point_t           pt,
	input  wire point_t           qry,
	output logic                  done,
	output out_item_t             result
);

	function automatic logic [COORD_W-1:0] abs_diff(coord_t a, coord_t b);
		logic [COORD_W-1:0] ua;
		logic [COORD_W-1:0] ub;
		ua = {~a[COORD_W-1], a[COORD_W-2:0]};
		ub = {~b[COORD_W-1], b[COORD_W-2:0]};
		return (ua > ub) ? (ua - ub) : (ub - ua);
	endfunction

	scan_tag_t          tag_s1, tag_s2, tag_s3;
	logic [IDX_W-1:0]   idx_s1, idx_s2, idx_s3;
	point_t             pt_s1, pt_s2, pt_s3;
	logic [COORD_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [SQ_W-1:0]    sqx_s2, sqy_s2, sqz_s2;
	logic [DIST_W-1:0]  dist_s3;

	logic [DIST_W-1:0]  best_d_q;
	logic [IDX_W-1:0]   best_idx_q;
	point_t             best_pt_q;
	logic               done_q;
	out_item_t          res_q;

	logic               take;
	logic [IDX_W-1:0]   sel_idx;
	point_t             sel_pt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			done_q <= tag_s3.valid && tag_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx;
		pt_s1  <= pt;
		dx_s1  <= abs_diff(qry.x, pt.x);
		dy_s1  <= abs_diff(qry.y, pt.y);
		dz_s1  <= abs_diff(qry.z, pt.z);

		idx_s2 <= idx_s1;
		pt_s2  <= pt_s1;
		sqx_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		sqy_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		sqz_s2 <= SQ_W'(dz_s1) * SQ_W'(dz_s1);

		idx_s3  <= idx_s2;
		pt_s3   <= pt_s2;
		dist_s3 <= DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2);
	end

	// strict less-than keeps the lowest index on ties
	always_comb begin
		take    = tag_s3.valid && (tag_s3.first || (dist_s3 < best_d_q));
		sel_idx = take ? idx_s3 : best_idx_q;
		sel_pt  = take ? pt_s3 : best_pt_q;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_d_q   <= dist_s3;
			best_idx_q <= idx_s3;
			best_pt_q  <= pt_s3;
		end
		res_q.status      <= STAT_FOUND;
		res_q.match_index <= IDX_OUT_W'(sel_idx);
		res_q.near_x      <= sel_pt.x;
		res_q.near_y      <= sel_pt.y;
		res_q.near_z      <= sel_pt.z;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the 3D nearest point search: directed and random insert/query traffic
`timescale 1ns / 1ps

module tb_top;
	import npsd_pkg::*;

	localparam int MAX_PTS  = 64;
	localparam int WD_LIMIT = 3000;

	typedef struct {
		in_item_t cmd;
		bit       drain_first;
	} backlog_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      done;
	out_item_t result;

	backlog_t  cmd_backlog[$];
	out_item_t reply_queue[$];

	point_t    table_pts[MAX_PTS];
	int        table_fill;

	point_t    gen_pts[$];
	int        gen_fill;

	int        errors;
	int        idle_cycles;
	int        gap_left;
	int        burst_left;
	bit        took;

	nearest_point_search_3d #(.MAX_POINTS(MAX_PTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	// expected result of one transaction; updates the shadow point table
	function automatic out_item_t search_table(in_item_t cmd);
		out_item_t       r;
		longint unsigned best;
		longint unsigned d;
		longint          dx;
		longint          dy;
		longint          dz;
		int              bi;
		r = '0;
		if (cmd.operation == OP_INSERT) begin
			if (table_fill >= MAX_PTS) begin
				r.status = STAT_FULL;
			end else begin
				table_pts[table_fill] = '{x: cmd.coord_x, y: cmd.coord_y, z: cmd.coord_z};
				table_fill++;
				r.status = STAT_INSERTED;
			end
		end else if (table_fill == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			best = 0;
			bi = 0;
			for (int i = 0; i < table_fill; i++) begin
				dx = longint'(cmd.coord_x) - longint'(table_pts[i].x);
				dy = longint'(cmd.coord_y) - longint'(table_pts[i].y);
				dz = longint'(cmd.coord_z) - longint'(table_pts[i].z);
				d = dx * dx + dy * dy + dz * dz;
				if (i == 0 || d < best) begin
					best = d;
					bi = i;
				end
			end
			r.status      = STAT_FOUND;
			r.match_index = bi[IDX_OUT_W-1:0];
			r.near_x      = table_pts[bi].x;
			r.near_y      = table_pts[bi].y;
			r.near_z      = table_pts[bi].z;
		end
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 200);
	endfunction

	// mode 0 random, 1 extreme, 2 near base
	function automatic coord_t pick_coord(int mode, coord_t base);
		coord_t c;
		case (mode)
			0: c = coord_t'($urandom_range(0, 65535));
			1: begin
				case ($urandom_range(0, 3))
					0: c = -16'sd32768;
					1: c = 16'sd32767;
					2: c = 16'sd0;
					default: c = -16'sd1;
				endcase
			end
			default: c = base + coord_t'($urandom_range(0, 16)) - 16'sd8;
		endcase
		return c;
	endfunction

	task automatic push_cmd(logic op, coord_t x, coord_t y, coord_t z, bit drain);
		backlog_t b;
		point_t   p;
		b.cmd.operation = op;
		b.cmd.coord_x = x;
		b.cmd.coord_y = y;
		b.cmd.coord_z = z;
		b.drain_first = drain;
		cmd_backlog = {cmd_backlog, b};
		if (op == OP_INSERT && gen_fill < MAX_PTS) begin
			p = '{x: x, y: y, z: z};
			gen_pts = {gen_pts, p};
			gen_fill++;
		end
	endtask

	task automatic push_random(logic op);
		point_t base;
		int     sel;
		int     mode;
		sel = $urandom_range(0, 99);
		if (gen_fill > 0)
			base = gen_pts[$urandom_range(0, gen_fill - 1)];
		else
			base = '0;
		if (op == OP_INSERT && gen_fill > 0 && sel < 15) begin
			push_cmd(op, base.x, base.y, base.z, 0);
		end else begin
			if (sel < 40)
				mode = 0;
			else if (sel < 60)
				mode = 1;
			else
				mode = (gen_fill > 0) ? 2 : 0;
			push_cmd(op, pick_coord(mode, base.x), pick_coord(mode, base.y),
				pick_coord(mode, base.z), 0);
		end
	endtask

	// driver
	always @(negedge clk) begin
		logic nxt_start;
		nxt_start = start;
		if (arst_n) begin
			if (start && took) begin
				nxt_start = 1'b0;
				took = 1'b0;
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					if (!cmd_backlog[0].drain_first || (reply_queue.size() == 0 && !busy)) begin
						item <= cmd_backlog[0].cmd;
						cmd_backlog.pop_front();
						nxt_start = 1'b1;
						gap_left = draw_gap();
					end
				end
			end
			start <= nxt_start;
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			idle_cycles++;
			if (start && !busy) begin
				reply_queue = {reply_queue, search_table(item)};
				took = 1'b1;
				idle_cycles = 0;
			end
			if (done) begin
				idle_cycles = 0;
				if (reply_queue.size() == 0) begin
					$display("%0t: result with no transaction pending: %p", $time, result);
					errors++;
				end else begin
					want = reply_queue.pop_front();
					if (result.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, result.status);
						errors++;
					end
					if (result.match_index !== want.match_index) begin
						$display("%0t: match_index expected %0d actual %0d", $time,
							want.match_index, result.match_index);
						errors++;
					end
					if (result.near_x !== want.near_x) begin
						$display("%0t: near_x expected %0d actual %0d", $time,
							want.near_x, result.near_x);
						errors++;
					end
					if (result.near_y !== want.near_y) begin
						$display("%0t: near_y expected %0d actual %0d", $time,
							want.near_y, result.near_y);
						errors++;
					end
					if (result.near_z !== want.near_z) begin
						$display("%0t: near_z expected %0d actual %0d", $time,
							want.near_z, result.near_z);
						errors++;
					end
				end
			end
			if (idle_cycles >= WD_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int  n;
		logic op;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		errors = 0;
		idle_cycles = 0;
		gap_left = 0;
		burst_left = 0;
		took = 1'b0;
		table_fill = 0;
		gen_fill = 0;

		// empty table, extremes, ties to the lowest index
		push_cmd(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 0);
		push_cmd(OP_QUERY, -16'sd32768, 16'sd32767, -16'sd1, 0);
		push_cmd(OP_INSERT, -16'sd32768, -16'sd32768, -16'sd32768, 0);
		push_cmd(OP_INSERT, 16'sd32767, 16'sd32767, 16'sd32767, 0);
		push_cmd(OP_QUERY, 16'sd32767, 16'sd32767, 16'sd32767, 0);
		push_cmd(OP_QUERY, -16'sd32768, -16'sd32768, -16'sd32768, 0);
		push_cmd(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 0);
		push_cmd(OP_QUERY, -16'sd1, -16'sd1, -16'sd1, 0);
		push_cmd(OP_INSERT, 16'sd0, 16'sd0, 16'sd0, 0);
		push_cmd(OP_INSERT, 16'sd0, 16'sd0, 16'sd0, 0);
		push_cmd(OP_QUERY, 16'sd0, 16'sd0, 16'sd0, 0);
		push_cmd(OP_INSERT, 16'sd256, -16'sd256, 16'sd128, 0);
		push_cmd(OP_QUERY, 16'sd128, -16'sd128, 16'sd64, 0);
		push_cmd(OP_INSERT, 16'sd32767, -16'sd32768, 16'sd0, 1);
		push_cmd(OP_QUERY, 16'sd32767, -16'sd32768, 16'sd1, 0);
		push_cmd(OP_QUERY, -16'sd32768, 16'sd32767, -16'sd32768, 0);
		push_cmd(OP_QUERY, 16'sd21845, -16'sd21846, 16'sd10922, 0);

		// random traffic: fill the table with queries mixed in, then mostly queries
		for (n = 0; n < 780; n++) begin
			if (gen_fill < MAX_PTS)
				op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_QUERY;
			else
				op = ($urandom_range(0, 99) < 15) ? OP_INSERT : OP_QUERY;
			push_random(op);
			if (n % 100 == 50)
				cmd_backlog[$].drain_first = 1;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() > 0 || start || reply_queue.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (errors == 0 && reply_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
